>>> design/asmlex_pkg.sv
// Package for the assembler lexer: item types, record codes, character codes
// and the small character-class helpers. No dependencies.
`timescale 1ns / 1ps

package asmlex_pkg;

   localparam int POSITION_WIDTH = 16;
   localparam int RESULT_DEPTH   = 3;

   typedef struct packed {
      logic [7:0] src_byte;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [7:0]  value_byte;
      logic [2:0]  token_type;
      logic [15:0] token_line;
      logic [15:0] token_column;
      logic [15:0] token_length;
      logic [1:0]  error_code;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_WORD    = 6'b000010,
      MODE_COMMENT = 6'b000100,
      MODE_QBODY   = 6'b001000,
      MODE_QESC    = 6'b010000,
      MODE_DROP    = 6'b100000
   } mode_type;

   localparam logic [1:0] KIND_VALUE = 2'd0;
   localparam logic [1:0] KIND_TOKEN = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] TOK_INTEGER    = 3'd0;
   localparam logic [2:0] TOK_IDENTIFIER = 3'd1;
   localparam logic [2:0] TOK_SEPARATOR  = 3'd2;
   localparam logic [2:0] TOK_CHAR       = 3'd3;

   localparam logic [1:0] ERR_CHAR_LONG    = 2'd0;
   localparam logic [1:0] ERR_BAD_NUMBER   = 2'd1;
   localparam logic [1:0] ERR_UNIDENTIFIED = 2'd2;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd3;

   localparam logic [1:0] QUOTE_CHAR    = 2'd0;
   localparam logic [1:0] QUOTE_STRING  = 2'd1;
   localparam logic [1:0] QUOTE_ADDRESS = 2'd2;

   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NL        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_BSLASH    = 8'h5C;
   localparam logic [7:0] CH_BACKTICK  = 8'h60;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_H   = 8'h68;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] ttype;
      logic [1:0] code;
      logic       drop;
   } fin_type;

   function automatic logic is_dec(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return is_dec(c) || (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic is_word(logic [7:0] c);
      return is_dec(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
         || c == 8'h5F;
   endfunction

   function automatic logic [7:0] quote_char(logic [1:0] k);
      logic [7:0] r;
      case (k)
         QUOTE_CHAR:   r = CH_SQUOTE;
         QUOTE_STRING: r = CH_DQUOTE;
         default:      r = CH_BACKTICK;
      endcase
      return r;
   endfunction

   // Classify a finished word from its last byte and body flags.
   function automatic fin_type fin_word(logic [7:0] last, logic len_ge2, logic all_dec,
                                        logic all_hex);
      fin_type f;
      logic    suffix;
      suffix = (last == CH_LOWER_B || last == CH_LOWER_H) && len_ge2;
      f      = '{kind: KIND_TOKEN, ttype: TOK_IDENTIFIER, code: ERR_CHAR_LONG, drop: 1'b0};
      if (all_dec && (is_dec(last) || suffix)) begin
         f.ttype = TOK_INTEGER;
      end else if (all_hex && suffix) begin
         if (last == CH_LOWER_H) begin
            f.ttype = TOK_INTEGER;
         end else begin
            f.kind  = KIND_ERROR;
            f.ttype = TOK_INTEGER;
            f.code  = ERR_BAD_NUMBER;
            f.drop  = 1'b1;
         end
      end
      return f;
   endfunction

endpackage

>>> design/assembler_lexer_top.sv
// Assembler lexer top level: input register, one-pass lexer logic, result queue.
// Depends on asmlex_pkg.
`timescale 1ns / 1ps

// Takes one source byte per item and returns value-byte, token-complete and
// error records, one record per rsp item, with last_of_run on the final record
// of each byte. A byte is registered, lexed in one pass and its zero to three
// records are loaded into a three-entry result queue. The block takes one
// byte per cycle while each byte gives at most one record and rsp_stall is
// low; a byte with more records holds the input while the queue drains one
// record per unstalled cycle. Records are registered in the queue as a byte advances.
// After an error, bytes are dropped until the byte flagged end_of_source,
// which always returns the lexer to its reset state for the next source.
module assembler_lexer_top #(
   parameter int POSITION_WIDTH = asmlex_pkg::POSITION_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  asmlex_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output asmlex_pkg::rsp_type rsp_payload
);

   localparam int P = POSITION_WIDTH;
   localparam int D = asmlex_pkg::RESULT_DEPTH;

   logic                  in_valid_ff;
   asmlex_pkg::req_type   in_ff;

   asmlex_pkg::mode_type  mode_ff, mode_in;
   logic [1:0]            quote_ff, quote_in;
   logic [P-1:0]          line_ff, line_in;
   logic [P-1:0]          col_ff, col_in;
   logic [P-1:0]          sline_ff, sline_in;
   logic [P-1:0]          scol_ff, scol_in;
   logic [P-1:0]          cnt_ff, cnt_in;
   logic                  dec_ff, dec_in;
   logic                  hex_ff, hex_in;
   logic [7:0]            prev_ff, prev_in;

   asmlex_pkg::rsp_type   q_ff [D];
   logic [1:0]            qcnt_ff;

   asmlex_pkg::rsp_type   res [D];
   logic [1:0]            rn;
   logic                  err_put;
   logic                  do_idle;
   asmlex_pkg::fin_type   fin;
   logic [7:0]            b;
   logic [7:0]            esc;
   logic                  eos;
   logic                  pop;
   logic                  advance;

   function automatic logic [P-1:0] sat_inc(logic [P-1:0] v);
      return (v == {P{1'b1}}) ? v : v + P'(1);
   endfunction

   function automatic asmlex_pkg::rsp_type mk(logic [1:0] k, logic [7:0] v, logic [2:0] t,
                                              logic pos, logic [1:0] code,
                                              logic [P-1:0] sl, logic [P-1:0] sc,
                                              logic [P-1:0] cc);
      asmlex_pkg::rsp_type r;
      r.record_kind  = k;
      r.value_byte   = v;
      r.token_type   = t;
      r.token_line   = pos ? 16'(sl) : 16'd0;
      r.token_column = pos ? 16'(sc) : 16'd0;
      r.token_length = pos ? 16'(cc) : 16'd0;
      r.error_code   = code;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   assign pop       = (qcnt_ff != 2'd0) && !rsp_stall;
   assign advance   = in_valid_ff && ((qcnt_ff == 2'd0) || (qcnt_ff == 2'd1 && !rsp_stall));
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = qcnt_ff != 2'd0;
   assign rsp_payload = q_ff[0];

   always_comb begin
      mode_in  = mode_ff;
      quote_in = quote_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      cnt_in   = cnt_ff;
      dec_in   = dec_ff;
      hex_in   = hex_ff;
      prev_in  = prev_ff;
      rn       = 2'd0;
      err_put  = 1'b0;
      do_idle  = 1'b0;
      fin      = '0;
      esc      = asmlex_pkg::CH_BSLASH;
      b        = in_ff.src_byte;
      eos      = in_ff.end_of_source;
      for (int i = 0; i < D; i++) begin
         res[i] = '0;
      end

      if (mode_ff != asmlex_pkg::MODE_DROP) begin
         col_in = sat_inc(col_in);
         unique case (mode_ff)
            asmlex_pkg::MODE_WORD: begin
               if (asmlex_pkg::is_word(b)) begin
                  if (cnt_in != '0) begin
                     if (!asmlex_pkg::is_dec(prev_in)) dec_in = 1'b0;
                     if (!asmlex_pkg::is_hex(prev_in)) hex_in = 1'b0;
                  end
                  prev_in = b;
                  cnt_in  = sat_inc(cnt_in);
                  res[rn] = mk(asmlex_pkg::KIND_VALUE, b, '0, 1'b0, '0,
                               sline_in, scol_in, cnt_in);
                  rn      = rn + 2'd1;
               end else begin
                  fin = asmlex_pkg::fin_word(prev_in, cnt_in >= P'(2), dec_in, hex_in);
                  res[rn] = mk(fin.kind, '0, fin.ttype, 1'b1, fin.code,
                               sline_in, scol_in, cnt_in);
                  rn      = rn + 2'd1;
                  err_put = fin.drop;
                  mode_in = fin.drop ? asmlex_pkg::MODE_DROP : asmlex_pkg::MODE_IDLE;
                  do_idle = !fin.drop;
               end
            end
            asmlex_pkg::MODE_COMMENT: begin
               if (b == asmlex_pkg::CH_NL) mode_in = asmlex_pkg::MODE_IDLE;
            end
            asmlex_pkg::MODE_QBODY: begin
               if (b == asmlex_pkg::quote_char(quote_in)) begin
                  mode_in = asmlex_pkg::MODE_IDLE;
                  if (cnt_in == '0) begin
                     mode_in = asmlex_pkg::MODE_IDLE;
                  end else if (quote_in == asmlex_pkg::QUOTE_CHAR && cnt_in > P'(1)) begin
                     res[rn] = mk(asmlex_pkg::KIND_ERROR, '0, '0, 1'b1,
                                  asmlex_pkg::ERR_CHAR_LONG, sline_in, scol_in, cnt_in);
                     rn      = rn + 2'd1;
                     err_put = 1'b1;
                     mode_in = asmlex_pkg::MODE_DROP;
                  end else begin
                     res[rn] = mk(asmlex_pkg::KIND_TOKEN, '0,
                                  asmlex_pkg::TOK_CHAR + {1'b0, quote_in}, 1'b1, '0,
                                  sline_in, scol_in, cnt_in);
                     rn      = rn + 2'd1;
                  end
               end else if (b == asmlex_pkg::CH_BSLASH) begin
                  mode_in = asmlex_pkg::MODE_QESC;
               end else begin
                  cnt_in  = sat_inc(cnt_in);
                  res[rn] = mk(asmlex_pkg::KIND_VALUE, b, '0, 1'b0, '0,
                               sline_in, scol_in, cnt_in);
                  rn      = rn + 2'd1;
               end
            end
            asmlex_pkg::MODE_QESC: begin
               case (b)
                  asmlex_pkg::CH_LOWER_N: esc = asmlex_pkg::CH_NL;
                  asmlex_pkg::CH_LOWER_T: esc = asmlex_pkg::CH_TAB;
                  asmlex_pkg::CH_LOWER_R: esc = asmlex_pkg::CH_CR;
                  default:                esc = asmlex_pkg::CH_BSLASH;
               endcase
               cnt_in  = sat_inc(cnt_in);
               res[rn] = mk(asmlex_pkg::KIND_VALUE, esc, '0, 1'b0, '0,
                            sline_in, scol_in, cnt_in);
               rn      = rn + 2'd1;
               mode_in = asmlex_pkg::MODE_QBODY;
            end
            default: begin
               mode_in = asmlex_pkg::MODE_IDLE;
               do_idle = 1'b1;
            end
         endcase

         if (do_idle) begin
            sline_in = line_in;
            scol_in  = col_in;
            if (b == asmlex_pkg::CH_SPACE || b == asmlex_pkg::CH_NL
                || b == asmlex_pkg::CH_TAB) begin
               mode_in = asmlex_pkg::MODE_IDLE;
            end else if (asmlex_pkg::is_word(b)) begin
               dec_in  = 1'b1;
               hex_in  = 1'b1;
               prev_in = b;
               cnt_in  = P'(1);
               mode_in = asmlex_pkg::MODE_WORD;
               res[rn] = mk(asmlex_pkg::KIND_VALUE, b, '0, 1'b0, '0,
                            sline_in, scol_in, cnt_in);
               rn      = rn + 2'd1;
            end else if (b == asmlex_pkg::CH_SEMI) begin
               mode_in = asmlex_pkg::MODE_COMMENT;
            end else if (b == asmlex_pkg::CH_SQUOTE || b == asmlex_pkg::CH_DQUOTE
                         || b == asmlex_pkg::CH_BACKTICK) begin
               quote_in = (b == asmlex_pkg::CH_SQUOTE) ? asmlex_pkg::QUOTE_CHAR :
                          (b == asmlex_pkg::CH_DQUOTE) ? asmlex_pkg::QUOTE_STRING :
                                                         asmlex_pkg::QUOTE_ADDRESS;
               cnt_in   = '0;
               mode_in  = asmlex_pkg::MODE_QBODY;
            end else begin
               cnt_in  = P'(1);
               res[rn] = mk(asmlex_pkg::KIND_VALUE, b, '0, 1'b0, '0,
                            sline_in, scol_in, cnt_in);
               rn      = rn + 2'd1;
               if (b == asmlex_pkg::CH_COLON || b == asmlex_pkg::CH_HASH
                   || b == asmlex_pkg::CH_DOT) begin
                  res[rn] = mk(asmlex_pkg::KIND_TOKEN, '0, asmlex_pkg::TOK_SEPARATOR,
                               1'b1, '0, sline_in, scol_in, cnt_in);
                  rn      = rn + 2'd1;
               end else begin
                  res[rn] = mk(asmlex_pkg::KIND_ERROR, '0, '0, 1'b1,
                               asmlex_pkg::ERR_UNIDENTIFIED, sline_in, scol_in, cnt_in);
                  rn      = rn + 2'd1;
                  err_put = 1'b1;
                  mode_in = asmlex_pkg::MODE_DROP;
               end
            end
         end

         if (mode_in != asmlex_pkg::MODE_DROP && b == asmlex_pkg::CH_NL) begin
            line_in = sat_inc(line_in);
            col_in  = '0;
         end
      end

      if (eos) begin
         if (mode_in == asmlex_pkg::MODE_WORD) begin
            fin = asmlex_pkg::fin_word(prev_in, cnt_in >= P'(2), dec_in, hex_in);
            res[rn] = mk(fin.kind, '0, fin.ttype, 1'b1, fin.code, sline_in, scol_in, cnt_in);
            rn      = rn + 2'd1;
         end else if (mode_in == asmlex_pkg::MODE_QBODY
                      || mode_in == asmlex_pkg::MODE_QESC) begin
            res[rn] = mk(asmlex_pkg::KIND_ERROR, '0, '0, 1'b1,
                         asmlex_pkg::ERR_UNTERMINATED, sline_in, scol_in, cnt_in);
            rn      = rn + 2'd1;
         end
         mode_in  = asmlex_pkg::MODE_IDLE;
         quote_in = '0;
         line_in  = P'(1);
         col_in   = '0;
         sline_in = '0;
         scol_in  = '0;
         cnt_in   = '0;
         dec_in   = 1'b1;
         hex_in   = 1'b1;
         prev_in  = '0;
      end

      for (int i = 0; i < D; i++) begin
         res[i].last_of_run = (2'(i + 1) == rn);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall) begin
         in_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= asmlex_pkg::MODE_IDLE;
         quote_ff <= '0;
         line_ff  <= P'(1);
         col_ff   <= '0;
         sline_ff <= '0;
         scol_ff  <= '0;
         cnt_ff   <= '0;
         dec_ff   <= 1'b1;
         hex_ff   <= 1'b1;
         prev_ff  <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         cnt_ff   <= cnt_in;
         dec_ff   <= dec_in;
         hex_ff   <= hex_in;
         prev_ff  <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qcnt_ff <= 2'd0;
      end else if (advance) begin
         qcnt_ff <= rn;
      end else if (pop) begin
         qcnt_ff <= qcnt_ff - 2'd1;
      end
      if (advance) begin
         for (int i = 0; i < D; i++) begin
            q_ff[i] <= res[i];
         end
      end else if (pop) begin
         for (int i = 0; i < D - 1; i++) begin
            q_ff[i] <= q_ff[i + 1];
         end
      end
   end

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && req_stall |=> in_valid_ff && $stable(in_ff))
      else $error("input register changed while held");

   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      advance && mode_ff == asmlex_pkg::MODE_DROP && !in_ff.end_of_source |-> rn == 2'd0)
      else $error("record produced while dropping");

   a_error_drops: assert property (@(posedge clock) disable iff (reset)
      advance && err_put && !in_ff.end_of_source |=> mode_ff == asmlex_pkg::MODE_DROP)
      else $error("error record without entering drop");

   a_eos_resets: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.end_of_source |=> mode_ff == asmlex_pkg::MODE_IDLE
                                         && line_ff == P'(1) && col_ff == '0)
      else $error("end of source did not restore reset state");

endmodule

>>> dv/asmlex_record_compare.sv
// Record predictor and comparator for the assembler lexer testbench: watches both
// item channels, predicts the records of every accepted source byte and compares.
// Depends on asmlex_pkg.
`timescale 1ns / 1ps

module asmlex_record_compare (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  asmlex_pkg::req_type req_payload,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  asmlex_pkg::rsp_type rsp_payload,
   output int                  fail_count,
   output int                  records_waiting
);

   asmlex_pkg::mode_type lx_mode;
   logic [1:0]           quote_sel;
   logic [15:0]          line_no;
   logic [15:0]          col_no;
   logic [15:0]          tok_line;
   logic [15:0]          tok_col;
   logic [15:0]          tok_len;
   logic                 dec_body;
   logic                 hex_body;
   logic [7:0]           prev_byte;

   asmlex_pkg::rsp_type expected_records[$];
   asmlex_pkg::rsp_type byte_records[$];
   int                  mismatches = 0;

   assign fail_count = mismatches;

   function automatic logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic digit_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic hex_ch(logic [7:0] c);
      return digit_ch(c) || (c >= "a" && c <= "f");
   endfunction

   function automatic logic word_ch(logic [7:0] c);
      return digit_ch(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   task automatic clear_state();
      lx_mode   = asmlex_pkg::MODE_IDLE;
      quote_sel = asmlex_pkg::QUOTE_CHAR;
      line_no   = 16'd1;
      col_no    = '0;
      tok_line  = '0;
      tok_col   = '0;
      tok_len   = '0;
      dec_body  = 1'b1;
      hex_body  = 1'b1;
      prev_byte = '0;
   endtask

   task automatic emit(input logic [1:0] kind, input logic [7:0] value,
                       input logic [2:0] ttype, input bit with_pos, input logic [1:0] code);
      asmlex_pkg::rsp_type r;
      r             = '0;
      r.record_kind = kind;
      r.value_byte  = value;
      r.token_type  = ttype;
      if (with_pos) begin
         r.token_line   = tok_line;
         r.token_column = tok_col;
         r.token_length = tok_len;
      end
      r.error_code = code;
      byte_records.insert(byte_records.size(), r);
   endtask

   task automatic word_char(input logic [7:0] b);
      if (tok_len != 0) begin
         if (!digit_ch(prev_byte)) dec_body = 1'b0;
         if (!hex_ch(prev_byte)) hex_body = 1'b0;
      end
      prev_byte = b;
      tok_len   = bump(tok_len);
      emit(asmlex_pkg::KIND_VALUE, b, '0, 1'b0, '0);
   endtask

   task automatic close_word();
      logic suffix;
      suffix = (prev_byte == asmlex_pkg::CH_LOWER_B || prev_byte == asmlex_pkg::CH_LOWER_H)
               && tok_len >= 2;
      lx_mode = asmlex_pkg::MODE_IDLE;
      if (dec_body && (digit_ch(prev_byte) || suffix)) begin
         emit(asmlex_pkg::KIND_TOKEN, '0, asmlex_pkg::TOK_INTEGER, 1'b1, '0);
      end else if (hex_body && suffix && prev_byte == asmlex_pkg::CH_LOWER_H) begin
         emit(asmlex_pkg::KIND_TOKEN, '0, asmlex_pkg::TOK_INTEGER, 1'b1, '0);
      end else if (hex_body && suffix) begin
         emit(asmlex_pkg::KIND_ERROR, '0, '0, 1'b1, asmlex_pkg::ERR_BAD_NUMBER);
         lx_mode = asmlex_pkg::MODE_DROP;
      end else begin
         emit(asmlex_pkg::KIND_TOKEN, '0, asmlex_pkg::TOK_IDENTIFIER, 1'b1, '0);
      end
   endtask

   task automatic start_token(input logic [7:0] b);
      tok_line = line_no;
      tok_col  = col_no;
      if (b == asmlex_pkg::CH_SPACE || b == asmlex_pkg::CH_NL || b == asmlex_pkg::CH_TAB) begin
         lx_mode = asmlex_pkg::MODE_IDLE;
      end else if (word_ch(b)) begin
         tok_len  = '0;
         dec_body = 1'b1;
         hex_body = 1'b1;
         lx_mode  = asmlex_pkg::MODE_WORD;
         word_char(b);
      end else if (b == asmlex_pkg::CH_SEMI) begin
         lx_mode = asmlex_pkg::MODE_COMMENT;
      end else if (b == asmlex_pkg::CH_SQUOTE || b == asmlex_pkg::CH_DQUOTE
                   || b == asmlex_pkg::CH_BACKTICK) begin
         quote_sel = (b == asmlex_pkg::CH_SQUOTE) ? asmlex_pkg::QUOTE_CHAR :
                     (b == asmlex_pkg::CH_DQUOTE) ? asmlex_pkg::QUOTE_STRING :
                                                    asmlex_pkg::QUOTE_ADDRESS;
         tok_len   = '0;
         lx_mode   = asmlex_pkg::MODE_QBODY;
      end else begin
         tok_len = 16'd1;
         emit(asmlex_pkg::KIND_VALUE, b, '0, 1'b0, '0);
         if (b == asmlex_pkg::CH_COLON || b == asmlex_pkg::CH_HASH
             || b == asmlex_pkg::CH_DOT) begin
            emit(asmlex_pkg::KIND_TOKEN, '0, asmlex_pkg::TOK_SEPARATOR, 1'b1, '0);
         end else begin
            emit(asmlex_pkg::KIND_ERROR, '0, '0, 1'b1, asmlex_pkg::ERR_UNIDENTIFIED);
            lx_mode = asmlex_pkg::MODE_DROP;
         end
      end
   endtask

   task automatic lex_byte(input asmlex_pkg::req_type it);
      logic [7:0]          b;
      logic [7:0]          closer;
      logic [7:0]          esc;
      asmlex_pkg::rsp_type r;
      b = it.src_byte;
      byte_records.delete();
      if (lx_mode != asmlex_pkg::MODE_DROP) begin
         col_no = bump(col_no);
         case (lx_mode)
            asmlex_pkg::MODE_WORD: begin
               if (word_ch(b)) begin
                  word_char(b);
               end else begin
                  close_word();
                  if (lx_mode == asmlex_pkg::MODE_IDLE) start_token(b);
               end
            end
            asmlex_pkg::MODE_COMMENT: begin
               if (b == asmlex_pkg::CH_NL) lx_mode = asmlex_pkg::MODE_IDLE;
            end
            asmlex_pkg::MODE_QBODY: begin
               closer = (quote_sel == asmlex_pkg::QUOTE_CHAR) ? asmlex_pkg::CH_SQUOTE :
                        (quote_sel == asmlex_pkg::QUOTE_STRING) ? asmlex_pkg::CH_DQUOTE :
                                                                  asmlex_pkg::CH_BACKTICK;
               if (b == closer) begin
                  lx_mode = asmlex_pkg::MODE_IDLE;
                  if (tok_len == 0) begin
                     lx_mode = asmlex_pkg::MODE_IDLE;
                  end else if (quote_sel == asmlex_pkg::QUOTE_CHAR && tok_len > 1) begin
                     emit(asmlex_pkg::KIND_ERROR, '0, '0, 1'b1, asmlex_pkg::ERR_CHAR_LONG);
                     lx_mode = asmlex_pkg::MODE_DROP;
                  end else begin
                     emit(asmlex_pkg::KIND_TOKEN, '0,
                          asmlex_pkg::TOK_CHAR + {1'b0, quote_sel}, 1'b1, '0);
                  end
               end else if (b == asmlex_pkg::CH_BSLASH) begin
                  lx_mode = asmlex_pkg::MODE_QESC;
               end else begin
                  tok_len = bump(tok_len);
                  emit(asmlex_pkg::KIND_VALUE, b, '0, 1'b0, '0);
               end
            end
            asmlex_pkg::MODE_QESC: begin
               esc = (b == asmlex_pkg::CH_LOWER_N) ? asmlex_pkg::CH_NL :
                     (b == asmlex_pkg::CH_LOWER_T) ? asmlex_pkg::CH_TAB :
                     (b == asmlex_pkg::CH_LOWER_R) ? asmlex_pkg::CH_CR : asmlex_pkg::CH_BSLASH;
               tok_len = bump(tok_len);
               emit(asmlex_pkg::KIND_VALUE, esc, '0, 1'b0, '0);
               lx_mode = asmlex_pkg::MODE_QBODY;
            end
            default: begin
               start_token(b);
            end
         endcase
         if (lx_mode != asmlex_pkg::MODE_DROP && b == asmlex_pkg::CH_NL) begin
            line_no = bump(line_no);
            col_no  = '0;
         end
      end
      if (it.end_of_source) begin
         if (lx_mode == asmlex_pkg::MODE_WORD) begin
            close_word();
         end else if (lx_mode == asmlex_pkg::MODE_QBODY || lx_mode == asmlex_pkg::MODE_QESC) begin
            emit(asmlex_pkg::KIND_ERROR, '0, '0, 1'b1, asmlex_pkg::ERR_UNTERMINATED);
         end
         clear_state();
      end
      foreach (byte_records[i]) begin
         r             = byte_records[i];
         r.last_of_run = (i == byte_records.size() - 1);
         expected_records.insert(expected_records.size(), r);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      asmlex_pkg::rsp_type want;
      if (reset) begin
         clear_state();
         expected_records.delete();
      end else begin
         if (req_valid && !req_stall) lex_byte(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (expected_records.size() == 0) begin
               $error("unexpected record of kind %0d", rsp_payload.record_kind);
               mismatches++;
            end else begin
               want = expected_records.pop_front();
               check_field("record_kind", 32'(want.record_kind),
                           32'(rsp_payload.record_kind));
               check_field("value_byte", 32'(want.value_byte),
                           32'(rsp_payload.value_byte));
               check_field("token_type", 32'(want.token_type),
                           32'(rsp_payload.token_type));
               check_field("token_line", 32'(want.token_line),
                           32'(rsp_payload.token_line));
               check_field("token_column", 32'(want.token_column),
                           32'(rsp_payload.token_column));
               check_field("token_length", 32'(want.token_length),
                           32'(rsp_payload.token_length));
               check_field("error_code", 32'(want.error_code),
                           32'(rsp_payload.error_code));
               check_field("last_of_run", 32'(want.last_of_run),
                           32'(rsp_payload.last_of_run));
            end
         end
      end
      records_waiting <= expected_records.size();
   end

endmodule

>>> dv/assembler_lexer_top_tb.sv
// Testbench top for assembler_lexer_top: builds source byte streams, drives them in
// random bursts, stalls the record channel and reports the verdict.
// Depends on asmlex_pkg, assembler_lexer_top and asmlex_record_compare.
`timescale 1ns / 1ps

module assembler_lexer_top_tb;

   localparam int CYCLE_LIMIT = 8_000_000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   asmlex_pkg::req_type req_payload;
   logic                rsp_valid;
   logic                rsp_stall;
   asmlex_pkg::rsp_type rsp_payload;
   int                  fail_count;
   int                  records_waiting;
   int                  cycle_count = 0;

   asmlex_pkg::req_type source_bytes[$];

   assembler_lexer_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   asmlex_record_compare record_compare (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .fail_count      (fail_count),
      .records_waiting (records_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("assembler_lexer_top_tb failed");
         $finish;
      end
   end

   task automatic put_byte(input logic [7:0] b);
      asmlex_pkg::req_type it;
      it.src_byte      = b;
      it.end_of_source = 1'b0;
      source_bytes.insert(source_bytes.size(), it);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic end_source();
      asmlex_pkg::req_type it;
      it               = source_bytes.pop_back();
      it.end_of_source = 1'b1;
      source_bytes.insert(source_bytes.size(), it);
   endtask

   function automatic logic [7:0] pick_digit();
      logic [7:0] k;
      k = 8'($urandom_range(0, 9));
      return "0" + k;
   endfunction

   function automatic logic [7:0] pick_hex();
      logic [7:0] k;
      k = 8'($urandom_range(0, 15));
      return (k < 10) ? "0" + k : "a" + k - 8'd10;
   endfunction

   function automatic logic [7:0] pick_word_char();
      logic [7:0] k;
      k = 8'($urandom_range(0, 62));
      if (k < 10) return "0" + k;
      else if (k < 36) return "A" + k - 8'd10;
      else if (k < 62) return "a" + k - 8'd36;
      else return "_";
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 2))
         0:       return asmlex_pkg::CH_SPACE;
         1:       return asmlex_pkg::CH_TAB;
         default: return asmlex_pkg::CH_NL;
      endcase
   endfunction

   task automatic add_quoted(input bit last);
      int         n;
      logic [7:0] open;
      logic [7:0] b;
      case ($urandom_range(0, 2))
         0:       open = asmlex_pkg::CH_SQUOTE;
         1:       open = asmlex_pkg::CH_DQUOTE;
         default: open = asmlex_pkg::CH_BACKTICK;
      endcase
      if (open == asmlex_pkg::CH_SQUOTE) n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : 1;
      else n = $urandom_range(0, 5);
      put_byte(open);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0) begin
            put_byte(asmlex_pkg::CH_BSLASH);
            case ($urandom_range(0, 3))
               0:       put_byte(asmlex_pkg::CH_LOWER_N);
               1:       put_byte(asmlex_pkg::CH_LOWER_T);
               2:       put_byte(asmlex_pkg::CH_LOWER_R);
               default: put_byte(8'($urandom_range(0, 255)));
            endcase
         end else begin
            do b = 8'($urandom_range(0, 255)); while (b == open || b == asmlex_pkg::CH_BSLASH);
            put_byte(b);
         end
      end
      if (!last || $urandom_range(0, 2) != 0) put_byte(open);
      else if ($urandom_range(0, 1) == 0) put_byte(asmlex_pkg::CH_BSLASH);
   endtask

   task automatic add_random_token(input bit last);
      int         n;
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0, 1: begin
            n = $urandom_range(1, 4);
            repeat (n) put_byte(pick_digit());
            case ($urandom_range(0, 2))
               0:       put_byte(asmlex_pkg::CH_LOWER_B);
               1:       put_byte(asmlex_pkg::CH_LOWER_H);
               default: ;
            endcase
         end
         2: begin
            n = $urandom_range(1, 4);
            repeat (n) put_byte(pick_hex());
            put_byte(($urandom_range(0, 3) == 0) ? asmlex_pkg::CH_LOWER_B
                                                 : asmlex_pkg::CH_LOWER_H);
         end
         3, 4: begin
            n = $urandom_range(0, 5);
            put_byte(pick_word_char());
            repeat (n) put_byte(pick_word_char());
         end
         5: begin
            case ($urandom_range(0, 2))
               0:       put_byte(asmlex_pkg::CH_COLON);
               1:       put_byte(asmlex_pkg::CH_HASH);
               default: put_byte(asmlex_pkg::CH_DOT);
            endcase
         end
         6, 7: add_quoted(last);
         8: begin
            n = $urandom_range(0, 6);
            put_byte(asmlex_pkg::CH_SEMI);
            repeat (n) begin
               do b = 8'($urandom_range(0, 255)); while (b == asmlex_pkg::CH_NL);
               put_byte(b);
            end
            put_byte(asmlex_pkg::CH_NL);
         end
         default: put_byte(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic add_random_source();
      int tokens;
      tokens = $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
         add_random_token(t == tokens - 1);
         if ($urandom_range(0, 3) != 0) put_byte(pick_blank());
      end
      end_source();
   endtask

   task automatic build_stimulus();
      int first_random;
      put_text("0b:x;");
      put_byte(asmlex_pkg::CH_NL);
      put_byte(asmlex_pkg::CH_DQUOTE);
      put_byte(asmlex_pkg::CH_BSLASH);
      put_text("q");
      put_byte(asmlex_pkg::CH_BSLASH);
      put_byte(asmlex_pkg::CH_LOWER_N);
      end_source();
      put_byte(asmlex_pkg::CH_SQUOTE);
      put_text("ab");
      put_byte(asmlex_pkg::CH_SQUOTE);
      put_byte(8'hFF);
      put_byte(8'h00);
      end_source();
      put_text("1fb");
      end_source();
      put_byte(asmlex_pkg::CH_BACKTICK);
      put_byte(asmlex_pkg::CH_BACKTICK);
      put_text("a");
      put_byte(asmlex_pkg::CH_CR);
      end_source();
      put_byte(asmlex_pkg::CH_SQUOTE);
      put_byte(asmlex_pkg::CH_BSLASH);
      put_byte(asmlex_pkg::CH_LOWER_T);
      put_byte(asmlex_pkg::CH_SQUOTE);
      put_byte(asmlex_pkg::CH_DOT);
      end_source();

      first_random = source_bytes.size();
      while (source_bytes.size() - first_random < 70) add_random_source();
   endtask

   initial begin
      int   sent;
      int   burst_left;
      int   gap_left;
      logic taken;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      build_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      sent       = 0;
      burst_left = 0;
      gap_left   = 0;
      while (sent < source_bytes.size()) begin
         @(posedge clock);
         taken = req_valid && !req_stall;
         if (taken) sent++;
         if (!req_valid || taken) begin
            if (sent == source_bytes.size()) begin
               req_valid <= 1'b0;
            end else begin
               if (burst_left == 0 && gap_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
               end
               if (gap_left > 0) begin
                  req_valid <= 1'b0;
                  gap_left--;
               end else begin
                  req_valid   <= 1'b1;
                  req_payload <= source_bytes[sent];
                  burst_left--;
               end
            end
         end
      end
      @(posedge clock);
      while (records_waiting != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0) begin
         $display("assembler_lexer_top_tb passed");
      end else begin
         $display("assembler_lexer_top_tb failed");
      end
      $finish;
   end

   initial begin
      int phase_left;
      int stall_pct;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      repeat (30) @(posedge clock);
      // hold off long enough for the block to fill and stall its input
      rsp_stall <= 1'b1;
      repeat (300) @(posedge clock);
      forever begin
         phase_left = $urandom_range(20, 200);
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            default: stall_pct = 75;
         endcase
         repeat (phase_left) begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            @(posedge clock);
         end
      end
   end

endmodule
